[hw/rtl/iee_pkg.sv]
// Shared types and constants for the infix expression evaluator.
package iee_pkg;

  typedef enum logic [2:0] {
    OP_END  = 3'd0,
    OP_LPAR = 3'd1,
    OP_ADD  = 3'd2,
    OP_SUB  = 3'd3,
    OP_MUL  = 3'd4,
    OP_DIV  = 3'd5
  } op_code_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_DIV_ZERO = 3'd1,
    ERR_OVERFLOW = 3'd2,
    ERR_OPERAND  = 3'd3,
    ERR_BAD_CHAR = 3'd4,
    ERR_BRACKETS = 3'd5
  } err_code_t;

  localparam logic [7:0] CH_END  = 8'h23;
  localparam logic [7:0] CH_LPAR = 8'h28;
  localparam logic [7:0] CH_RPAR = 8'h29;
  localparam logic [7:0] CH_MUL  = 8'h2a;
  localparam logic [7:0] CH_ADD  = 8'h2b;
  localparam logic [7:0] CH_SUB  = 8'h2d;
  localparam logic [7:0] CH_DIV  = 8'h2f;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef struct packed {
    logic     start;
    op_code_t op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic        div_zero;
    logic [31:0] result;
  } alu_rsp_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sd2147483647) r = 32'h7fffffff;
    else if (v < -66'sd2147483648) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

[hw/rtl/iee_alu.sv]
// Shared multi-cycle arithmetic unit: add, subtract, multiply and restoring divide.
module iee_alu
  import iee_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  localparam int QW = 32 + FRAC_BITS;
  localparam int CW = $clog2(QW + 1);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} state_t;

  state_t            state;
  logic signed [31:0] a;
  logic signed [31:0] b;
  logic              neg;
  logic [QW-1:0]     quo;
  logic [32:0]       rem;
  logic [31:0]       dvs;
  logic [CW-1:0]     cnt;
  logic signed [65:0] prod;
  logic [32:0]       rem_sh;
  logic [33:0]       trial;
  logic [63:0]       mag;
  logic signed [65:0] wide;

  assign rem_sh = {rem[31:0], quo[QW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b0, dvs};

  always_comb begin
    mag = 64'(quo);
    wide = neg ? -$signed({2'b0, mag}) : $signed({2'b0, mag});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp   <= '0;
    end else begin
      rsp.done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.start) begin
            a  <= req.a;
            b  <= req.b;
            rsp.div_zero <= 1'b0;
            case (req.op)
              OP_ADD: begin
                rsp.result <= sat32(66'($signed(req.a)) + 66'($signed(req.b)));
                rsp.done   <= 1'b1;
              end
              OP_SUB: begin
                rsp.result <= sat32(66'($signed(req.a)) - 66'($signed(req.b)));
                rsp.done   <= 1'b1;
              end
              OP_MUL: state <= S_MUL;
              default: begin
                if (req.b == '0) begin
                  rsp.div_zero <= 1'b1;
                  rsp.done     <= 1'b1;
                end else begin
                  neg <= req.a[31] ^ req.b[31];
                  quo <= QW'({req.a[31] ? 32'(-req.a) : req.a}) << FRAC_BITS;
                  dvs <= req.b[31] ? 32'(-req.b) : req.b;
                  rem <= '0;
                  cnt <= CW'(QW);
                  state <= S_DIV;
                end
              end
            endcase
          end
        end
        S_MUL: begin
          prod  <= 66'(a * b);
          state <= S_FIN;
        end
        S_FIN: begin
          if (prod < 0) rsp.result <= sat32(-((-prod) >>> FRAC_BITS));
          else rsp.result <= sat32(prod >>> FRAC_BITS);
          rsp.done <= 1'b1;
          state    <= S_IDLE;
        end
        S_DIV: begin
          if (cnt == '0) begin
            rsp.result <= sat32(wide);
            rsp.done   <= 1'b1;
            state      <= S_IDLE;
          end else begin
            if (!trial[33]) begin
              rem <= trial[32:0];
              quo <= {quo[QW-2:0], 1'b1};
            end else begin
              rem <= rem_sh;
              quo <= {quo[QW-2:0], 1'b0};
            end
            cnt <= cnt - 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/infix_expression_evaluator.sv]
// Top level: two-stack infix evaluator with a shared arithmetic unit.
// Digits and brackets are handled in the decide step; each reduction goes through the shared
// arithmetic unit (add/sub, multiply, or divide at one quotient bit a cycle).
// One item at a time; in_ready is low while the sequencer works or a result waits.
// Synchronous reset empties both stacks and clears the error; stacks need no clearing pass.
module infix_expression_evaluator
  import iee_pkg::*;
#(
  parameter int STACK_DEPTH = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  symbol,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] value,
  output logic [2:0]  error_code
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic [2:0] {S_IDLE, S_DECIDE, S_RD, S_WAIT, S_OUT} state_t;

  state_t    state;
  op_code_t  opstk [STACK_DEPTH];
  logic [31:0] valstk [STACK_DEPTH];
  logic [CW-1:0] opc;
  logic [CW-1:0] vc;
  logic [2:0]  err;
  logic [7:0]  sym;
  op_code_t    code;
  alu_req_t    req;
  alu_rsp_t    rsp;
  op_code_t    top;
  logic        defer;

  always_comb begin
    if (opc == '0) top = OP_END;
    else top = opstk[AW'(opc - 1'b1)];
    if (code == OP_ADD || code == OP_SUB) defer = (top != OP_END && top != OP_LPAR);
    else defer = (top == OP_MUL || top == OP_DIV);
  end

  iee_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      opc       <= CW'(1);
      vc        <= '0;
      err       <= ERR_NONE;
      out_valid <= 1'b0;
      req.start <= 1'b0;
      opstk[0]  <= OP_END;
    end else begin
      req.start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            sym <= symbol;
            case (symbol)
              CH_ADD: code <= OP_ADD;
              CH_SUB: code <= OP_SUB;
              CH_MUL: code <= OP_MUL;
              default: code <= OP_DIV;
            endcase
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state <= S_IDLE;
          if (sym == CH_END) begin
            if (err != ERR_NONE) begin
              state <= S_OUT;
            end else if (top == OP_LPAR) begin
              err <= ERR_BRACKETS;
              state <= S_OUT;
            end else if (top != OP_END) begin
              state <= S_RD;
            end else begin
              if (vc != CW'(1)) err <= ERR_OPERAND;
              state <= S_OUT;
            end
          end else if (err != ERR_NONE) begin
            state <= S_IDLE;
          end else if (sym >= CH_ZERO && sym <= CH_NINE) begin
            if (vc >= CW'(STACK_DEPTH)) err <= ERR_OVERFLOW;
            else begin
              valstk[AW'(vc)] <= sat32(66'(sym - CH_ZERO) <<< FRAC_BITS);
              vc <= vc + 1'b1;
            end
          end else if (sym == CH_LPAR) begin
            if (opc >= CW'(STACK_DEPTH)) err <= ERR_OVERFLOW;
            else begin
              opstk[AW'(opc)] <= OP_LPAR;
              opc <= opc + 1'b1;
            end
          end else if (sym == CH_RPAR) begin
            if (top == OP_LPAR) opc <= opc - 1'b1;
            else if (top == OP_END) err <= ERR_BRACKETS;
            else state <= S_RD;
          end else if (sym == CH_ADD || sym == CH_SUB || sym == CH_MUL || sym == CH_DIV) begin
            if (defer) state <= S_RD;
            else if (opc >= CW'(STACK_DEPTH)) err <= ERR_OVERFLOW;
            else begin
              opstk[AW'(opc)] <= code;
              opc <= opc + 1'b1;
            end
          end else begin
            err <= ERR_BAD_CHAR;
          end
        end
        S_RD: begin
          if (opc > CW'(1)) opc <= opc - 1'b1;
          if (vc < CW'(2) || vc > CW'(STACK_DEPTH)) begin
            err <= ERR_OPERAND;
            state <= (sym == CH_END) ? S_OUT : S_IDLE;
          end else begin
            req.start <= 1'b1;
            req.op <= top;
            req.a  <= valstk[AW'(vc - CW'(2))];
            req.b  <= valstk[AW'(vc - 1'b1)];
            state  <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (rsp.done) begin
            if (rsp.div_zero) begin
              err <= ERR_DIV_ZERO;
              state <= (sym == CH_END) ? S_OUT : S_IDLE;
            end else begin
              vc <= vc - 1'b1;
              valstk[AW'(vc - CW'(2))] <= rsp.result;
              state <= S_DECIDE;
            end
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid  <= 1'b1;
            error_code <= err;
            value      <= (err == ERR_NONE) ? valstk[0] : '0;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            opc   <= CW'(1);
            vc    <= '0;
            err   <= ERR_NONE;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_opc_range: assert property (@(posedge clk) disable iff (rst)
    opc >= CW'(1) && opc <= CW'(STACK_DEPTH)) else $error("operator count out of range");
  a_vc_range: assert property (@(posedge clk) disable iff (rst)
    vc <= CW'(STACK_DEPTH)) else $error("operand count out of range");
  a_err_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_NONE |-> value == '0) else $error("value on error");
`endif

endmodule
